// ----- src/evest_pkg.sv -----
// Shared types and constants for the encoder velocity estimator.
// Holds the request and response word layouts and the fixed field widths.
// No dependencies.
`default_nettype none

package evest_pkg;

   // Field widths fixed by the interface
   localparam int POSITION_BITS = 14;
   localparam int ACCEL_BITS    = 24;
   localparam int GAIN_BITS     = 24;
   localparam int SPEED_BITS    = 32;

   // Default window depths
   localparam int SPEED_WINDOW_DEF = 100;
   localparam int ACCEL_WINDOW_DEF = 50;

   // Wheel gain after reset: 1.0 in unsigned Q8.16
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'd65536;

   // Unwrap threshold, scaled to the encoder modulus
   localparam int POS_MODULUS  = 1 << POSITION_BITS;
   localparam int UNWRAP_LIMIT = (8000 * POS_MODULUS) / 16384;

   // Output scaling: speed = floor((125*q*gain + 32*accel + 16000) / 32000)
   localparam int ROUND_SCALE = 125;
   localparam int ROUND_BIAS  = 16000;

   typedef struct packed {
      logic        [POSITION_BITS-1:0] left_position;
      logic        [POSITION_BITS-1:0] right_position;
      logic signed [ACCEL_BITS-1:0]    accel_sample;
   } req_word_type;

   typedef struct packed {
      logic signed [SPEED_BITS-1:0] left_speed;
      logic signed [SPEED_BITS-1:0] right_speed;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- src/evest_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for the change and acceleration rings. No dependencies.
`default_nettype none

module evest_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold the last word when not reading
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/encoder_velocity_estimator_core.sv -----
// Encoder velocity estimator top level: ring memories, running sums and
// the fixed-point speed pipeline. Depends on evest_pkg and evest_ram.
//
//   channel   ports                                 direction  word
//   request   req_valid, req_stall, req_word        in         two positions + accel
//   response  rsp_valid, rsp_stall, rsp_word        out        left and right speed
//   config    csr_wr_en, csr_wr_data                in         wheel gain
//
// One word per cycle sustained while rsp_stall is low; an accepted word passes the
// stage registers, then the response register. The ring read at acceptance and the
// write as the word leaves stage 1 set the rate; a forwarding register serves the
// back-to-back case on one entry. Reset clears positions, sums, slots and a fill flag
// per ring; an entry counts as zero until its ring wraps, so there is no clearing pass.
// rsp_stall backs up the pipeline stage by stage; req_stall rises only when
// the first stage holds a word that cannot move on.
`default_nettype none

module encoder_velocity_estimator_core #(
   parameter int SPEED_WINDOW = evest_pkg::SPEED_WINDOW_DEF,
   parameter int ACCEL_WINDOW = evest_pkg::ACCEL_WINDOW_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire evest_pkg::req_word_type             req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output evest_pkg::rsp_word_type                  rsp_word,
   input  wire logic                                csr_wr_en,
   input  wire logic [evest_pkg::GAIN_BITS-1:0]     csr_wr_data
);

   // Widths
   localparam int PB      = evest_pkg::POSITION_BITS;
   localparam int CHG_W   = PB + 1;
   localparam int DIFF_W  = PB + 2;
   localparam int GAIN_W  = evest_pkg::GAIN_BITS;
   localparam int ACL_W   = evest_pkg::ACCEL_BITS;
   localparam int SPD_W   = evest_pkg::SPEED_BITS;

   localparam int CSLOT_W = (SPEED_WINDOW > 1) ? $clog2(SPEED_WINDOW) : 1;
   localparam int ASLOT_W = (ACCEL_WINDOW > 1) ? $clog2(ACCEL_WINDOW) : 1;

   // Change sum and its truncating divide by the window (reciprocal multiply)
   localparam int SUM_W     = CHG_W + $clog2(SPEED_WINDOW);
   localparam int MAG_W     = SUM_W - 1;
   localparam int SPD_SHIFT = MAG_W + $clog2(SPEED_WINDOW);
   localparam int SPD_RW    = MAG_W + 2;
   localparam longint unsigned SPD_RECIP =
      ((longint'(1) << SPD_SHIFT) + longint'(SPEED_WINDOW) - 1) / longint'(SPEED_WINDOW);
   localparam int SPD_PW    = MAG_W + SPD_RW;
   localparam int QMAG_W    = CHG_W - 1;

   // Gain product
   localparam int P_W  = CHG_W + GAIN_W + 1;
   localparam int PH_W = P_W - 8;
   localparam int C_W  = 16;

   // Acceleration total and floor divide by 125 after a shift by 3
   localparam int ACC_W     = ACL_W + $clog2(ACCEL_WINDOW);
   localparam int U_W       = ACC_W + 1;
   localparam int M_W       = U_W - 3;
   localparam int ACC_SHIFT = M_W + 7;
   localparam int ACC_RW    = M_W + 2;
   localparam longint unsigned ACC_RECIP =
      ((longint'(1) << ACC_SHIFT) + longint'(evest_pkg::ROUND_SCALE) - 1)
      / longint'(evest_pkg::ROUND_SCALE);
   localparam int ACC_PW    = M_W + ACC_RW;
   localparam int QQ_W      = M_W - 6;

   localparam int V_W = PH_W + 1;
   localparam logic signed [V_W-1:0] SAT_HI =
      V_W'((longint'(1) << (SPD_W - 1)) - 1);
   localparam logic signed [V_W-1:0] SAT_LO = -SAT_HI - V_W'(1);

   // ---------------------------------------------------------------
   // Control and architectural state
   // ---------------------------------------------------------------
   logic [GAIN_W-1:0]   gain_ff;
   logic [PB-1:0]       prev_ff [2];
   logic signed [SUM_W-1:0] sum_ff [2];
   logic signed [ACC_W-1:0] total_ff;
   logic [CSLOT_W-1:0]  cslot_ff;
   logic [ASLOT_W-1:0]  aslot_ff;
   logic                cfill_ff;
   logic                afill_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, rsp_valid_ff;
   logic go1, go2, go3, go4, go5, go6, go7;
   logic accept;
   logic leave1;

   // Stage 1: new changes, ring slots, forwarding
   logic signed [CHG_W-1:0] s1_d_ff [2];
   logic signed [ACL_W-1:0] s1_a_ff;
   logic [CSLOT_W-1:0]      s1_cslot_ff;
   logic [ASLOT_W-1:0]      s1_aslot_ff;
   logic                    s1_cfwd_ff, s1_afwd_ff;
   logic                    s1_cfill_ff, s1_afill_ff;
   logic signed [CHG_W-1:0] s1_cfwd_data_ff [2];
   logic signed [ACL_W-1:0] s1_afwd_data_ff;

   // Later stages
   logic signed [SUM_W-1:0]  s2_sum_ff [2];
   logic signed [ACC_W-1:0]  s2_total_ff;
   logic [SPD_PW-1:0]        s3_prod_ff [2];
   logic                     s3_neg_ff [2];
   logic signed [ACC_W-1:0]  s3_total_ff;
   logic signed [P_W-1:0]    s4_p_ff [2];
   logic signed [ACC_W-1:0]  s4_total_ff;
   logic [M_W-1:0]           s5_m_ff [2];
   logic                     s5_neg_ff [2];
   logic signed [PH_W-1:0]   s5_ph_ff [2];
   logic [ACC_PW-1:0]        s6_mp_ff [2];
   logic                     s6_neg_ff [2];
   logic signed [PH_W-1:0]   s6_ph_ff [2];
   evest_pkg::rsp_word_type  rsp_word_ff;

   // Next values
   logic signed [CHG_W-1:0] d_in [2];
   logic [PB-1:0]           pos_in [2];
   logic [CSLOT_W-1:0]      cslot_in;
   logic [ASLOT_W-1:0]      aslot_in;
   logic                    cwrap, awrap;
   logic                    cfwd_in, afwd_in;
   logic signed [SUM_W-1:0] sum_in [2];
   logic signed [ACC_W-1:0] total_in;
   logic [SPD_PW-1:0]       prod_in [2];
   logic                    neg2_in [2];
   logic signed [P_W-1:0]   p_in [2];
   logic [M_W-1:0]          m_in [2];
   logic                    neg4_in [2];
   logic signed [PH_W-1:0]  ph_in [2];
   logic [ACC_PW-1:0]       mp_in [2];
   logic signed [V_W-1:0]   v_in [2];
   logic signed [SPD_W-1:0] speed_in [2];

   // Memory ports
   logic [2*CHG_W-1:0] cram_rd, cram_wr;
   logic [ACL_W-1:0]   aram_rd;

   // ---------------------------------------------------------------
   // Flow control: each stage loads when empty or when it moves on
   // ---------------------------------------------------------------
   assign go7    = !rsp_valid_ff || !rsp_stall;
   assign go6    = !v6_ff || go7;
   assign go5    = !v5_ff || go6;
   assign go4    = !v4_ff || go5;
   assign go3    = !v3_ff || go4;
   assign go2    = !v2_ff || go3;
   assign go1    = !v1_ff || go2;
   assign accept = req_valid && go1;
   assign leave1 = v1_ff && go2;

   assign req_stall = !go1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------
   // Accept stage: unwrap position changes, advance slots
   // ---------------------------------------------------------------
   always_comb begin
      logic signed [DIFF_W-1:0] diff;
      pos_in[0] = req_word.left_position;
      pos_in[1] = req_word.right_position;
      for (int i = 0; i < 2; i++) begin
         // left change is negated
         if (i == 0) begin
            diff = $signed({2'b00, prev_ff[i]}) - $signed({2'b00, pos_in[i]});
         end else begin
            diff = $signed({2'b00, pos_in[i]}) - $signed({2'b00, prev_ff[i]});
         end
         if (diff < -DIFF_W'(evest_pkg::UNWRAP_LIMIT)) begin
            diff = diff + DIFF_W'(evest_pkg::POS_MODULUS);
         end
         if (diff > DIFF_W'(evest_pkg::UNWRAP_LIMIT)) begin
            diff = diff - DIFF_W'(evest_pkg::POS_MODULUS);
         end
         d_in[i] = diff[CHG_W-1:0];
      end
   end

   assign cwrap    = (cslot_ff == CSLOT_W'(SPEED_WINDOW - 1));
   assign awrap    = (aslot_ff == ASLOT_W'(ACCEL_WINDOW - 1));
   assign cslot_in = cwrap ? '0 : cslot_ff + CSLOT_W'(1);
   assign aslot_in = awrap ? '0 : aslot_ff + ASLOT_W'(1);

   // The word leaving stage 1 writes the entry this word reads
   assign cfwd_in = v1_ff && (cslot_ff == s1_cslot_ff);
   assign afwd_in = v1_ff && (aslot_ff == s1_aslot_ff);

   // ---------------------------------------------------------------
   // Stage 1: pick the outgoing ring entry, update running sums
   // ---------------------------------------------------------------
   always_comb begin
      logic signed [CHG_W-1:0] old_d;
      logic signed [ACL_W-1:0] old_a;
      for (int i = 0; i < 2; i++) begin
         if (s1_cfwd_ff) begin
            old_d = s1_cfwd_data_ff[i];
         end else if (s1_cfill_ff) begin
            old_d = $signed(cram_rd[i*CHG_W +: CHG_W]);
         end else begin
            old_d = '0;
         end
         sum_in[i] = sum_ff[i] + SUM_W'(s1_d_ff[i]) - SUM_W'(old_d);
      end
      if (s1_afwd_ff) begin
         old_a = s1_afwd_data_ff;
      end else if (s1_afill_ff) begin
         old_a = $signed(aram_rd);
      end else begin
         old_a = '0;
      end
      total_in = total_ff + ACC_W'(s1_a_ff) - ACC_W'(old_a);
      cram_wr  = {s1_d_ff[1], s1_d_ff[0]};
   end

   // ---------------------------------------------------------------
   // Stage 2: magnitude of each sum times the window reciprocal
   // ---------------------------------------------------------------
   always_comb begin
      logic signed [SUM_W-1:0] neg_sum;
      for (int i = 0; i < 2; i++) begin
         neg2_in[i] = s2_sum_ff[i][SUM_W-1];
         neg_sum    = -s2_sum_ff[i];
         prod_in[i] = (neg2_in[i] ? neg_sum[MAG_W-1:0] : s2_sum_ff[i][MAG_W-1:0])
                      * SPD_RW'(SPD_RECIP);
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: truncated quotient, restore sign, multiply by gain
   // ---------------------------------------------------------------
   always_comb begin
      logic [QMAG_W-1:0]       qmag;
      logic signed [CHG_W-1:0] q;
      for (int i = 0; i < 2; i++) begin
         qmag   = s3_prod_ff[i][SPD_SHIFT +: QMAG_W];
         q      = s3_neg_ff[i] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
         p_in[i] = q * $signed({1'b0, gain_ff});
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: split product, fold in acceleration, prepare floor divide
   // ---------------------------------------------------------------
   always_comb begin
      logic [C_W-1:0]          c;
      logic signed [U_W-1:0]   u;
      logic signed [M_W-1:0]   w;
      logic signed [M_W:0]     m_neg;
      for (int i = 0; i < 2; i++) begin
         ph_in[i]   = s4_p_ff[i][P_W-1:8];
         c          = C_W'(evest_pkg::ROUND_SCALE) * C_W'(s4_p_ff[i][7:0])
                      + C_W'(evest_pkg::ROUND_BIAS);
         u          = U_W'(s4_total_ff) + $signed(U_W'(c[C_W-1:5]));
         w          = u[U_W-1:3];
         neg4_in[i] = w[M_W-1];
         m_neg      = (M_W+1)'(evest_pkg::ROUND_SCALE - 1) - (M_W+1)'(w);
         m_in[i]    = neg4_in[i] ? m_neg[M_W-1:0] : w[M_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: reciprocal multiply by 1/125
   // ---------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         mp_in[i] = s5_m_ff[i] * ACC_RW'(ACC_RECIP);
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: add the acceleration term and saturate
   // ---------------------------------------------------------------
   always_comb begin
      logic [QQ_W-1:0]       qq;
      logic signed [V_W-1:0] sq;
      for (int i = 0; i < 2; i++) begin
         qq = s6_mp_ff[i][ACC_SHIFT +: QQ_W];
         sq = s6_neg_ff[i] ? -$signed(V_W'(qq)) : $signed(V_W'(qq));
         v_in[i] = V_W'(s6_ph_ff[i]) + sq;
         if (v_in[i] > SAT_HI) begin
            speed_in[i] = SAT_HI[SPD_W-1:0];
         end else if (v_in[i] < SAT_LO) begin
            speed_in[i] = SAT_LO[SPD_W-1:0];
         end else begin
            speed_in[i] = v_in[i][SPD_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------
   // Ring memories
   // ---------------------------------------------------------------
   evest_ram #(
      .WIDTH (2 * CHG_W),
      .DEPTH (SPEED_WINDOW)
   ) u_change_ram (
      .clock   (clock),
      .wr_en   (leave1),
      .wr_addr (s1_cslot_ff),
      .wr_data (cram_wr),
      .rd_en   (accept),
      .rd_addr (cslot_ff),
      .rd_data (cram_rd)
   );

   evest_ram #(
      .WIDTH (ACL_W),
      .DEPTH (ACCEL_WINDOW)
   ) u_accel_ram (
      .clock   (clock),
      .wr_en   (leave1),
      .wr_addr (s1_aslot_ff),
      .wr_data (s1_a_ff),
      .rd_en   (accept),
      .rd_addr (aslot_ff),
      .rd_data (aram_rd)
   );

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= evest_pkg::GAIN_RESET;
         prev_ff[0]   <= '0;
         prev_ff[1]   <= '0;
         sum_ff[0]    <= '0;
         sum_ff[1]    <= '0;
         total_ff     <= '0;
         cslot_ff     <= '0;
         aslot_ff     <= '0;
         cfill_ff     <= 1'b0;
         afill_ff     <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
         // advance positions and slots on each accepted word
         if (accept) begin
            prev_ff[0] <= pos_in[0];
            prev_ff[1] <= pos_in[1];
            cslot_ff   <= cslot_in;
            aslot_ff   <= aslot_in;
            if (cwrap) begin
               cfill_ff <= 1'b1;
            end
            if (awrap) begin
               afill_ff <= 1'b1;
            end
         end
         // commit running sums as a word leaves stage 1
         if (leave1) begin
            sum_ff[0] <= sum_in[0];
            sum_ff[1] <= sum_in[1];
            total_ff  <= total_in;
         end
         if (go1) v1_ff <= req_valid;
         if (go2) v2_ff <= v1_ff;
         if (go3) v3_ff <= v2_ff;
         if (go4) v4_ff <= v3_ff;
         if (go5) v5_ff <= v4_ff;
         if (go6) v6_ff <= v5_ff;
         if (go7) rsp_valid_ff <= v6_ff;
      end
   end

   // ---------------------------------------------------------------
   // Pipeline payload registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (go1) begin
         s1_d_ff[0]         <= d_in[0];
         s1_d_ff[1]         <= d_in[1];
         s1_a_ff            <= req_word.accel_sample;
         s1_cslot_ff        <= cslot_ff;
         s1_aslot_ff        <= aslot_ff;
         s1_cfwd_ff         <= cfwd_in;
         s1_afwd_ff         <= afwd_in;
         s1_cfill_ff        <= cfill_ff;
         s1_afill_ff        <= afill_ff;
         s1_cfwd_data_ff[0] <= s1_d_ff[0];
         s1_cfwd_data_ff[1] <= s1_d_ff[1];
         s1_afwd_data_ff    <= s1_a_ff;
      end
      if (go2) begin
         s2_sum_ff[0] <= sum_in[0];
         s2_sum_ff[1] <= sum_in[1];
         s2_total_ff  <= total_in;
      end
      if (go3) begin
         s3_prod_ff[0] <= prod_in[0];
         s3_prod_ff[1] <= prod_in[1];
         s3_neg_ff[0]  <= neg2_in[0];
         s3_neg_ff[1]  <= neg2_in[1];
         s3_total_ff   <= s2_total_ff;
      end
      if (go4) begin
         s4_p_ff[0]  <= p_in[0];
         s4_p_ff[1]  <= p_in[1];
         s4_total_ff <= s3_total_ff;
      end
      if (go5) begin
         s5_m_ff[0]   <= m_in[0];
         s5_m_ff[1]   <= m_in[1];
         s5_neg_ff[0] <= neg4_in[0];
         s5_neg_ff[1] <= neg4_in[1];
         s5_ph_ff[0]  <= ph_in[0];
         s5_ph_ff[1]  <= ph_in[1];
      end
      if (go6) begin
         s6_mp_ff[0]  <= mp_in[0];
         s6_mp_ff[1]  <= mp_in[1];
         s6_neg_ff[0] <= s5_neg_ff[0];
         s6_neg_ff[1] <= s5_neg_ff[1];
         s6_ph_ff[0]  <= s5_ph_ff[0];
         s6_ph_ff[1]  <= s5_ph_ff[1];
      end
      if (go7) begin
         rsp_word_ff.left_speed  <= speed_in[0];
         rsp_word_ff.right_speed <= speed_in[1];
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
`ifndef SYNTHESIS
   // Back-to-back hits on one ring entry only happen once the ring has wrapped
   a_fwd_after_fill : assert property (@(posedge clock) disable iff (reset)
      (accept && v1_ff && (cslot_ff == s1_cslot_ff)) |-> cfill_ff)
      else $error("change ring forwarding before fill");

   // Slots stay inside their windows
   a_slots_in_range : assert property (@(posedge clock) disable iff (reset)
      (cslot_ff <= CSLOT_W'(SPEED_WINDOW - 1)) && (aslot_ff <= ASLOT_W'(ACCEL_WINDOW - 1)))
      else $error("ring slot out of range");

   // No result right after reset
   a_reset_empty : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!rsp_valid_ff && !v1_ff))
      else $error("pipeline not empty after reset");

   // A new result only comes from a word in the last stage
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v6_ff))
      else $error("result without a source word");
`endif

endmodule

`default_nettype wire
